@@ hdl/mst_pkg.sv @@
// ----------------------------------------------------------------------------
// mst_pkg
// Shared types and constants for the multi-slot interval timer.
// ----------------------------------------------------------------------------
package mst_pkg;

  localparam int DEF_SLOTS      = 16;
  localparam int DEF_TIME_WIDTH = 32;
  localparam int MAX_RESULTS    = 16;
  localparam int QDEPTH         = 2;
  localparam int SLOT_W         = 4;
  localparam int PERIOD_W       = 32;
  localparam int OP_W           = 3;
  localparam int EV_W           = 3;

  typedef enum logic [OP_W-1:0] {
    OP_TICK   = 3'd0,
    OP_ADD    = 3'd1,
    OP_BEGIN  = 3'd2,
    OP_FINISH = 3'd3,
    OP_CANCEL = 3'd4
  } op_e;

  localparam logic [EV_W-1:0] EV_EXPIRED      = 3'd0;
  localparam logic [EV_W-1:0] EV_ADDED        = 3'd1;
  localparam logic [EV_W-1:0] EV_TABLE_FULL   = 3'd2;
  localparam logic [EV_W-1:0] EV_GRANTED      = 3'd3;
  localparam logic [EV_W-1:0] EV_REFUSED      = 3'd4;
  localparam logic [EV_W-1:0] EV_FINISHED     = 3'd5;
  localparam logic [EV_W-1:0] EV_CANCELLED    = 3'd6;
  localparam logic [EV_W-1:0] EV_CANCEL_REFUS = 3'd7;

  localparam logic [1:0] MK_ARMED   = 2'd0;
  localparam logic [1:0] MK_EXPIRED = 2'd1;
  localparam logic [1:0] MK_SERVICE = 2'd2;

  typedef struct packed {
    op_e                 op;
    logic [SLOT_W-1:0]   slot;
    logic                inr;
    logic [PERIOD_W-1:0] period;
    logic                keep;
  } cmd_t;

endpackage

@@ hdl/multi_slot_interval_timer.sv @@
// ----------------------------------------------------------------------------
// multi_slot_interval_timer
// Timer slot table with a time counter advanced by each tick command; reports
// expiries on tick and handles add, service and cancel commands.
// ----------------------------------------------------------------------------
//  channel  | handshake         | payload
//  ---------+-------------------+----------------------------------------------
//  command  | start / busy      | operation_i, slot_i, period_i, keep_i
//  result   | strobe_o (1 cyc)  | event_res_o, slot_out_o, last_o
//
//  Tick: one slot per cycle through the registered table read.
//  Add: a search from slot 0 upward for a free slot.
//  Begin service, finish service and cancel: done in the back end's idle state.
//  A two-entry command queue holds transactions while the back end works;
//  busy is high while both entries are taken.
//  Reset clears the active bits and marks at once; no clearing pass.
//  Results leave through a register and cannot be held off by the receiver.
// ----------------------------------------------------------------------------
module multi_slot_interval_timer import mst_pkg::*; #(
  parameter int SLOTS      = DEF_SLOTS,
  parameter int TIME_WIDTH = DEF_TIME_WIDTH
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  logic [OP_W-1:0]     operation_i,
  input  logic [SLOT_W-1:0]   slot_i,
  input  logic [PERIOD_W-1:0] period_i,
  input  logic                keep_i,
  output logic                strobe_o,
  output logic [EV_W-1:0]     event_res_o,
  output logic [SLOT_W-1:0]   slot_out_o,
  output logic                last_o
);

  logic head_v;
  cmd_t head;
  logic pop;

  mst_front #(
    .SLOTS (SLOTS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .operation_i (operation_i),
    .slot_i      (slot_i),
    .period_i    (period_i),
    .keep_i      (keep_i),
    .head_v_o    (head_v),
    .head_o      (head),
    .pop_i       (pop)
  );

  mst_back #(
    .SLOTS      (SLOTS),
    .TIME_WIDTH (TIME_WIDTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_v_i    (head_v),
    .head_i      (head),
    .pop_o       (pop),
    .strobe_o    (strobe_o),
    .event_res_o (event_res_o),
    .slot_out_o  (slot_out_o),
    .last_o      (last_o)
  );

  a_queued: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && (operation_i <= OP_CANCEL) |=> head_v)
    else $error("accepted transaction not queued");

  a_only_expiry_multi: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o && !last_o |-> event_res_o == EV_EXPIRED)
    else $error("non-final result that is not an expiry");

  a_full_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o && (event_res_o == EV_TABLE_FULL) |-> slot_out_o == '0 && last_o)
    else $error("table full result malformed");

endmodule

@@ hdl/mst_front.sv @@
// ----------------------------------------------------------------------------
// mst_front
// Accepts transactions, drops unused operation codes, checks the slot range
// and holds accepted commands in a two-entry queue.
// ----------------------------------------------------------------------------
module mst_front import mst_pkg::*; #(
  parameter int SLOTS = DEF_SLOTS
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  logic [OP_W-1:0]     operation_i,
  input  logic [SLOT_W-1:0]   slot_i,
  input  logic [PERIOD_W-1:0] period_i,
  input  logic                keep_i,
  output logic                head_v_o,
  output cmd_t                head_o,
  input  logic                pop_i
);

  localparam int PtrW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int CntW = $clog2(QDEPTH + 1);

  cmd_t            q_mem [QDEPTH];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            push;
  cmd_t            cmd;

  assign busy     = (cnt_q == CntW'(QDEPTH));
  assign head_v_o = (cnt_q != '0);
  assign head_o   = q_mem[rd_q];

  always_comb begin
    cmd.op     = op_e'(operation_i);
    cmd.slot   = slot_i;
    cmd.inr    = (int'(slot_i) < SLOTS);
    cmd.period = period_i;
    cmd.keep   = keep_i;
    push       = start && !busy && (operation_i <= OP_CANCEL);
  end

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push) begin
      wr_d = (wr_q == PtrW'(QDEPTH - 1)) ? '0 : wr_q + PtrW'(1);
    end
    if (pop_i) begin
      rd_d = (rd_q == PtrW'(QDEPTH - 1)) ? '0 : rd_q + PtrW'(1);
    end
    if (push && !pop_i) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (!push && pop_i) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem[wr_q] <= cmd;
    end
  end

endmodule

@@ hdl/mst_back.sv @@
// ----------------------------------------------------------------------------
// mst_back
// Owns the slot table and the time counter and carries out queued commands:
// tick scans one slot per cycle, add searches for the lowest free slot.
// ----------------------------------------------------------------------------
module mst_back import mst_pkg::*; #(
  parameter int SLOTS      = DEF_SLOTS,
  parameter int TIME_WIDTH = DEF_TIME_WIDTH
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              head_v_i,
  input  cmd_t              head_i,
  output logic              pop_o,
  output logic              strobe_o,
  output logic [EV_W-1:0]   event_res_o,
  output logic [SLOT_W-1:0] slot_out_o,
  output logic              last_o
);

  localparam int IdxW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CntW = $clog2(MAX_RESULTS + 1);
  localparam int CmpW = (TIME_WIDTH > PERIOD_W) ? TIME_WIDTH : PERIOD_W;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(SLOTS - 1);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_TSCAN  = 2'd1;
  localparam logic [1:0] ST_TFLUSH = 2'd2;
  localparam logic [1:0] ST_ASCAN  = 2'd3;

  logic [1:0]            state_q, state_d;
  logic [SLOTS-1:0]      active_q, active_d;
  logic [1:0]            mark_q [SLOTS];
  logic [1:0]            mark_d [SLOTS];
  logic [TIME_WIDTH-1:0] time_q, time_d;
  logic [IdxW-1:0]       idx_q, idx_d;
  logic                  iss_v_q, iss_v_d;
  logic                  chk_v_q, chk_v_d;
  logic [IdxW-1:0]       chk_idx_q, chk_idx_d;
  logic [CntW-1:0]       cnt_q, cnt_d;
  logic                  pend_v_q, pend_v_d;
  logic [IdxW-1:0]       pend_idx_q, pend_idx_d;
  logic [PERIOD_W-1:0]   add_per_q, add_per_d;

  logic                  res_v_q, res_v_d;
  logic [EV_W-1:0]       res_ev_q, res_ev_d;
  logic [SLOT_W-1:0]     res_slot_q, res_slot_d;
  logic                  res_last_q, res_last_d;

  logic [PERIOD_W-1:0]   per_mem [SLOTS];
  logic [TIME_WIDTH-1:0] st_mem  [SLOTS];
  logic [PERIOD_W-1:0]   rd_per_q;
  logic [TIME_WIDTH-1:0] rd_st_q;
  logic                  we_per, we_st;
  logic [IdxW-1:0]       wa;
  logic [PERIOD_W-1:0]   wd_per;

  logic [TIME_WIDTH-1:0] elapsed;
  logic                  hit;
  logic [IdxW-1:0]       s;

  assign strobe_o    = res_v_q;
  assign event_res_o = res_ev_q;
  assign slot_out_o  = res_slot_q;
  assign last_o      = res_last_q;

  assign elapsed = time_q - rd_st_q;
  assign hit     = chk_v_q && (cnt_q < CntW'(MAX_RESULTS)) && active_q[chk_idx_q] &&
                   (mark_q[chk_idx_q] == MK_ARMED) &&
                   (CmpW'(elapsed) > CmpW'(rd_per_q));
  assign s       = IdxW'(head_i.slot);

  always_comb begin
    state_d    = state_q;
    active_d   = active_q;
    mark_d     = mark_q;
    time_d     = time_q;
    idx_d      = idx_q;
    iss_v_d    = iss_v_q;
    chk_v_d    = chk_v_q;
    chk_idx_d  = chk_idx_q;
    cnt_d      = cnt_q;
    pend_v_d   = pend_v_q;
    pend_idx_d = pend_idx_q;
    add_per_d  = add_per_q;
    res_v_d    = 1'b0;
    res_ev_d   = res_ev_q;
    res_slot_d = res_slot_q;
    res_last_d = res_last_q;
    pop_o      = 1'b0;
    we_per     = 1'b0;
    we_st      = 1'b0;
    wa         = idx_q;
    wd_per     = add_per_q;

    unique case (state_q)
      ST_IDLE: begin
        if (head_v_i) begin
          pop_o      = 1'b1;
          res_slot_d = head_i.slot;
          res_last_d = 1'b1;
          unique case (head_i.op)
            OP_TICK: begin
              time_d   = time_q + TIME_WIDTH'(1);
              idx_d    = '0;
              iss_v_d  = 1'b1;
              chk_v_d  = 1'b0;
              cnt_d    = '0;
              pend_v_d = 1'b0;
              state_d  = ST_TSCAN;
            end
            OP_ADD: begin
              add_per_d = head_i.period;
              idx_d     = '0;
              state_d   = ST_ASCAN;
            end
            OP_BEGIN: begin
              res_v_d = 1'b1;
              if (head_i.inr && active_q[s]) begin
                mark_d[s] = MK_SERVICE;
                res_ev_d  = EV_GRANTED;
              end else begin
                if (head_i.inr) begin
                  active_d[s] = 1'b0;
                  mark_d[s]   = MK_ARMED;
                end
                res_ev_d = EV_REFUSED;
              end
            end
            OP_FINISH: begin
              res_v_d  = 1'b1;
              res_ev_d = EV_FINISHED;
              if (head_i.inr) begin
                if (head_i.keep) begin
                  if (active_q[s]) begin
                    mark_d[s] = MK_ARMED;
                    we_st     = 1'b1;
                    wa        = s;
                  end
                end else begin
                  active_d[s] = 1'b0;
                  mark_d[s]   = MK_ARMED;
                end
              end
            end
            OP_CANCEL: begin
              res_v_d = 1'b1;
              if (head_i.inr && (mark_q[s] != MK_SERVICE)) begin
                active_d[s] = 1'b0;
                mark_d[s]   = MK_ARMED;
                res_ev_d    = EV_CANCELLED;
              end else begin
                res_ev_d = EV_CANCEL_REFUS;
              end
            end
          endcase
        end
      end

      ST_TSCAN: begin
        chk_v_d   = iss_v_q;
        chk_idx_d = idx_q;
        if (iss_v_q) begin
          if (idx_q == LastIdx) begin
            iss_v_d = 1'b0;
          end else begin
            idx_d = idx_q + IdxW'(1);
          end
        end
        if (hit) begin
          mark_d[chk_idx_q] = MK_EXPIRED;
          cnt_d             = cnt_q + CntW'(1);
          pend_v_d          = 1'b1;
          pend_idx_d        = chk_idx_q;
          if (pend_v_q) begin
            res_v_d    = 1'b1;
            res_ev_d   = EV_EXPIRED;
            res_slot_d = SLOT_W'(pend_idx_q);
            res_last_d = 1'b0;
          end
        end
        if ((!iss_v_q && !chk_v_q) || (cnt_q == CntW'(MAX_RESULTS))) begin
          iss_v_d = 1'b0;
          chk_v_d = 1'b0;
          state_d = ST_TFLUSH;
        end
      end

      ST_TFLUSH: begin
        if (pend_v_q) begin
          res_v_d    = 1'b1;
          res_ev_d   = EV_EXPIRED;
          res_slot_d = SLOT_W'(pend_idx_q);
          res_last_d = 1'b1;
        end
        pend_v_d = 1'b0;
        state_d  = ST_IDLE;
      end

      ST_ASCAN: begin
        res_last_d = 1'b1;
        if (!active_q[idx_q]) begin
          active_d[idx_q] = 1'b1;
          mark_d[idx_q]   = MK_ARMED;
          we_per          = 1'b1;
          we_st           = 1'b1;
          res_v_d         = 1'b1;
          res_ev_d        = EV_ADDED;
          res_slot_d      = SLOT_W'(idx_q);
          state_d         = ST_IDLE;
        end else if (idx_q == LastIdx) begin
          res_v_d    = 1'b1;
          res_ev_d   = EV_TABLE_FULL;
          res_slot_d = '0;
          state_d    = ST_IDLE;
        end else begin
          idx_d = idx_q + IdxW'(1);
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      active_q <= '0;
      mark_q   <= '{default: MK_ARMED};
      time_q   <= '0;
      idx_q    <= '0;
      iss_v_q  <= 1'b0;
      chk_v_q  <= 1'b0;
      cnt_q    <= '0;
      pend_v_q <= 1'b0;
      res_v_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      active_q <= active_d;
      mark_q   <= mark_d;
      time_q   <= time_d;
      idx_q    <= idx_d;
      iss_v_q  <= iss_v_d;
      chk_v_q  <= chk_v_d;
      cnt_q    <= cnt_d;
      pend_v_q <= pend_v_d;
      res_v_q  <= res_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    chk_idx_q  <= chk_idx_d;
    pend_idx_q <= pend_idx_d;
    add_per_q  <= add_per_d;
    res_ev_q   <= res_ev_d;
    res_slot_q <= res_slot_d;
    res_last_q <= res_last_d;
  end

  // slot table: one write port, read at the scan index
  always_ff @(posedge clk_i) begin
    if (we_per) begin
      per_mem[wa] <= wd_per;
    end
    if (we_st) begin
      st_mem[wa] <= time_q;
    end
    rd_per_q <= per_mem[idx_q];
    rd_st_q  <= st_mem[idx_q];
  end

endmodule
